FILE: hdl/samc_pkg.sv
// types and constants shared by the servo axis motion controller
package samc_pkg;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] target_position;
        logic [15:0]        speed_req;
        logic [31:0]        now_ms;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] servo_angle;
    } out_item_t;

    localparam logic [1:0] CMD_MOVE  = 2'd0;
    localparam logic [1:0] CMD_SPEED = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [2:0] ST_MOVED    = 3'd0;
    localparam logic [2:0] ST_RANGE    = 3'd1;
    localparam logic [2:0] ST_FAST     = 3'd2;
    localparam logic [2:0] ST_FINISHED = 3'd3;
    localparam logic [2:0] ST_ACCEPTED = 3'd4;
    localparam logic [2:0] ST_CLAMPED  = 3'd5;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_POS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_GAIN  = 3'd4;

    localparam logic [3:0] OP_NONE         = 4'd0;
    localparam logic [3:0] OP_LOAD         = 4'd1;
    localparam logic [3:0] OP_MUL_TRAVEL   = 4'd2;
    localparam logic [3:0] OP_DIV_TRAVEL   = 4'd3;
    localparam logic [3:0] OP_MUL_SPAN     = 4'd4;
    localparam logic [3:0] OP_DIV_SPAN     = 4'd5;
    localparam logic [3:0] OP_INTERP       = 4'd6;
    localparam logic [3:0] OP_MUL_V        = 4'd7;
    localparam logic [3:0] OP_MUL_DEG      = 4'd8;
    localparam logic [3:0] OP_COMMIT_MOVE  = 4'd9;
    localparam logic [3:0] OP_COMMIT_SPEED = 4'd10;
    localparam logic [3:0] OP_RESULT       = 4'd11;

    localparam logic [31:0] MS_SCALE        = 32'd256000;
    localparam logic [31:0] DEG_PER_RAD_Q16 = 32'd3754936;

    localparam int DIV_DVD_W = 48;
    localparam int DIV_DVS_W = 32;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] status;
    } dp_ctrl_t;

    typedef struct packed {
        logic [1:0] command;
        logic       range_ok;
        logic       too_fast;
        logic       run_ok;
        logic       div_busy;
    } dp_stat_t;

endpackage

FILE: hdl/samc_div.sv
// serial restoring divider, one quotient bit per cycle
module samc_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [samc_pkg::DIV_DVD_W-1:0] dividend,
    input  logic [samc_pkg::DIV_DVS_W-1:0] divisor,
    output logic                           busy,
    output logic [samc_pkg::DIV_DVD_W-1:0] quotient
);
    import samc_pkg::*;

    localparam int CNT_W = $clog2(DIV_DVD_W);

    logic                 busy_reg, busy_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_DVS_W-1:0] rem_reg, rem_next;
    logic [DIV_DVD_W-1:0] dq_reg, dq_next;
    logic [DIV_DVS_W-1:0] dvs_reg, dvs_next;
    logic [DIV_DVS_W:0]   trial;
    logic [DIV_DVS_W:0]   diff;
    logic                 ge;

    always_comb
    begin
        trial     = {rem_reg, dq_reg[DIV_DVD_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        ge        = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_DVD_W - 1);
            rem_next  = '0;
            dq_next   = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIV_DVS_W-1:0] : trial[DIV_DVS_W-1:0];
            dq_next  = {dq_reg[DIV_DVD_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = dq_reg;

endmodule

FILE: hdl/samc_datapath.sv
// datapath: settings, axis state, shared multiplier and divider
module samc_datapath #(
    parameter int POS_FRAC_BITS = 12,
    parameter int TIME_WIDTH    = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  samc_pkg::dp_ctrl_t                ctrl,
    output samc_pkg::dp_stat_t                stat,
    input  samc_pkg::in_item_t                in_item,
    input  logic                              cfg_we,
    input  logic [samc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [15:0]                       cfg_data,
    output samc_pkg::out_item_t               out_item
);
    import samc_pkg::*;

    localparam int DEG_SHIFT = 2 * POS_FRAC_BITS + 16;

    logic [1:0]            cmd_reg, cmd_next;
    logic signed [15:0]    pos_reg, pos_next;
    logic [15:0]           spd_reg, spd_next;
    logic [TIME_WIDTH-1:0] now_reg, now_next;

    logic signed [15:0]    min_pos_reg, min_pos_next;
    logic signed [15:0]    max_pos_reg, max_pos_next;
    logic [15:0]           max_speed_reg, max_speed_next;
    logic signed [15:0]    zero_off_reg, zero_off_next;
    logic signed [15:0]    gain_reg, gain_next;

    logic signed [15:0]    cur_pos_reg, cur_pos_next;
    logic [TIME_WIDTH-1:0] ready_reg, ready_next;
    logic [TIME_WIDTH-1:0] start_time_reg, start_time_next;
    logic [TIME_WIDTH-1:0] duration_reg, duration_next;
    logic signed [15:0]    start_pos_reg, start_pos_next;
    logic signed [15:0]    end_pos_reg, end_pos_next;

    logic [63:0]           prod_reg, prod_next;
    logic                  vneg_reg, vneg_next;
    out_item_t             result_reg, result_next;

    logic signed [16:0]    diff;
    logic [16:0]           mag;
    logic [15:0]           lim;
    logic [15:0]           s_req;
    logic                  clamp;
    logic [15:0]           spd_eff;
    logic signed [16:0]    span;
    logic [16:0]           span_mag;
    logic signed [16:0]    pz;
    logic [16:0]           pz_mag;
    logic [15:0]           g_mag;
    logic [TIME_WIDTH-1:0] elapsed;
    logic [31:0]           mul_a, mul_b;
    logic [63:0]           shifted;
    logic [7:0]            angle;
    logic signed [16:0]    interp;
    logic                  div_start;
    logic [DIV_DVD_W-1:0]  div_dvd;
    logic [DIV_DVS_W-1:0]  div_dvs;
    logic                  div_busy;
    logic [DIV_DVD_W-1:0]  quot;

    samc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .quotient (quot)
    );

    always_comb
    begin
        diff     = {cur_pos_reg[15], cur_pos_reg} - {pos_reg[15], pos_reg};
        mag      = diff[16] ? 17'(-diff) : 17'(diff);
        lim      = (max_speed_reg == '0) ? 16'd1 : max_speed_reg;
        s_req    = (spd_reg == '0) ? 16'd1 : spd_reg;
        clamp    = s_req > lim;
        spd_eff  = (cmd_reg == CMD_SPEED) ? (clamp ? lim : s_req) : lim;
        span     = {end_pos_reg[15], end_pos_reg} - {start_pos_reg[15], start_pos_reg};
        span_mag = span[16] ? 17'(-span) : 17'(span);
        pz       = {pos_reg[15], pos_reg} + {zero_off_reg[15], zero_off_reg};
        pz_mag   = pz[16] ? 17'(-pz) : 17'(pz);
        g_mag    = gain_reg[15] ? 16'(-gain_reg) : 16'(gain_reg);
        elapsed  = now_reg - start_time_reg;
        shifted  = prod_reg >> DEG_SHIFT;
        if (vneg_reg)
        begin
            angle = 8'd0;
        end
        else if (|shifted[63:8])
        begin
            angle = 8'd255;
        end
        else
        begin
            angle = shifted[7:0];
        end
        interp = span[16] ? ({start_pos_reg[15], start_pos_reg} - signed'(quot[16:0]))
                          : ({start_pos_reg[15], start_pos_reg} + signed'(quot[16:0]));
    end

    always_comb
    begin
        case (ctrl.op)
            OP_MUL_TRAVEL:
            begin
                mul_a = 32'(mag);
                mul_b = MS_SCALE;
            end
            OP_MUL_SPAN:
            begin
                mul_a = 32'(span_mag);
                mul_b = 32'(elapsed);
            end
            OP_MUL_V:
            begin
                mul_a = 32'(pz_mag);
                mul_b = 32'(g_mag);
            end
            default:
            begin
                mul_a = prod_reg[31:0];
                mul_b = DEG_PER_RAD_Q16;
            end
        endcase
    end

    always_comb
    begin
        div_start = (ctrl.op == OP_DIV_TRAVEL) || (ctrl.op == OP_DIV_SPAN);
        if (ctrl.op == OP_DIV_SPAN)
        begin
            div_dvd = prod_reg[DIV_DVD_W-1:0];
            div_dvs = DIV_DVS_W'(duration_reg);
        end
        else
        begin
            div_dvd = DIV_DVD_W'(prod_reg >> POS_FRAC_BITS);
            div_dvs = DIV_DVS_W'(spd_eff);
        end
    end

    always_comb
    begin
        cmd_next        = cmd_reg;
        pos_next        = pos_reg;
        spd_next        = spd_reg;
        now_next        = now_reg;
        min_pos_next    = min_pos_reg;
        max_pos_next    = max_pos_reg;
        max_speed_next  = max_speed_reg;
        zero_off_next   = zero_off_reg;
        gain_next       = gain_reg;
        cur_pos_next    = cur_pos_reg;
        ready_next      = ready_reg;
        start_time_next = start_time_reg;
        duration_next   = duration_reg;
        start_pos_next  = start_pos_reg;
        end_pos_next    = end_pos_reg;
        prod_next       = prod_reg;
        vneg_next       = vneg_reg;
        result_next     = result_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_POS:   min_pos_next   = cfg_data;
                CFG_MAX_POS:   max_pos_next   = cfg_data;
                CFG_MAX_SPEED: max_speed_next = cfg_data;
                CFG_ZERO_OFF:  zero_off_next  = cfg_data;
                CFG_MAP_GAIN:  gain_next      = cfg_data;
                default:       ;
            endcase
        end

        case (ctrl.op)
            OP_LOAD:
            begin
                cmd_next = in_item.command;
                pos_next = in_item.target_position;
                spd_next = in_item.speed_req;
                now_next = in_item.now_ms[TIME_WIDTH-1:0];
            end
            OP_MUL_TRAVEL, OP_MUL_SPAN, OP_MUL_DEG:
            begin
                prod_next = mul_a * mul_b;
            end
            OP_MUL_V:
            begin
                prod_next = mul_a * mul_b;
                vneg_next = pz[16] ^ gain_reg[15];
            end
            OP_INTERP:
            begin
                pos_next = interp[15:0];
            end
            OP_COMMIT_MOVE:
            begin
                ready_next   = now_reg + quot[TIME_WIDTH-1:0];
                cur_pos_next = pos_reg;
                result_next  = '{status: ST_MOVED, servo_angle: angle};
            end
            OP_COMMIT_SPEED:
            begin
                duration_next   = quot[TIME_WIDTH-1:0];
                start_pos_next  = cur_pos_reg;
                end_pos_next    = pos_reg;
                start_time_next = now_reg;
                result_next     = '{status: (clamp ? ST_CLAMPED : ST_ACCEPTED),
                                    servo_angle: 8'd0};
            end
            OP_RESULT:
            begin
                result_next = '{status: ctrl.status, servo_angle: 8'd0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pos_reg    <= 16'sh8000;
            max_pos_reg    <= 16'sh7fff;
            max_speed_reg  <= 16'd256;
            zero_off_reg   <= 16'sd0;
            gain_reg       <= 16'sd4096;
            cur_pos_reg    <= '0;
            ready_reg      <= '0;
            start_time_reg <= '0;
            duration_reg   <= '0;
            start_pos_reg  <= '0;
            end_pos_reg    <= '0;
            cmd_reg        <= CMD_NOP;
        end
        else
        begin
            min_pos_reg    <= min_pos_next;
            max_pos_reg    <= max_pos_next;
            max_speed_reg  <= max_speed_next;
            zero_off_reg   <= zero_off_next;
            gain_reg       <= gain_next;
            cur_pos_reg    <= cur_pos_next;
            ready_reg      <= ready_next;
            start_time_reg <= start_time_next;
            duration_reg   <= duration_next;
            start_pos_reg  <= start_pos_next;
            end_pos_reg    <= end_pos_next;
            cmd_reg        <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        spd_reg    <= spd_next;
        now_reg    <= now_next;
        prod_reg   <= prod_next;
        vneg_reg   <= vneg_next;
        result_reg <= result_next;
    end

    assign stat.command  = cmd_reg;
    assign stat.range_ok = (pos_reg >= min_pos_reg) && (pos_reg <= max_pos_reg);
    assign stat.too_fast = ready_reg > now_reg;
    assign stat.run_ok   = (duration_reg != '0) && (elapsed <= duration_reg);
    assign stat.div_busy = div_busy;
    assign out_item      = result_reg;

endmodule

FILE: hdl/samc_ctrl.sv
// controller state machine sequencing the datapath
module samc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  samc_pkg::dp_stat_t  stat,
    output samc_pkg::dp_ctrl_t  ctrl
);
    import samc_pkg::*;

    localparam logic [4:0] S_IDLE       = 5'd0;
    localparam logic [4:0] S_DECODE     = 5'd1;
    localparam logic [4:0] S_MOVE_CHK   = 5'd2;
    localparam logic [4:0] S_TRV_MUL    = 5'd3;
    localparam logic [4:0] S_TRV_DIV    = 5'd4;
    localparam logic [4:0] S_TRV_WAIT   = 5'd5;
    localparam logic [4:0] S_DEG_MUL1   = 5'd6;
    localparam logic [4:0] S_DEG_MUL2   = 5'd7;
    localparam logic [4:0] S_MV_COMMIT  = 5'd8;
    localparam logic [4:0] S_SPD_MUL    = 5'd9;
    localparam logic [4:0] S_SPD_DIV    = 5'd10;
    localparam logic [4:0] S_SPD_WAIT   = 5'd11;
    localparam logic [4:0] S_SPD_COMMIT = 5'd12;
    localparam logic [4:0] S_RUN_MUL    = 5'd13;
    localparam logic [4:0] S_RUN_DIV    = 5'd14;
    localparam logic [4:0] S_RUN_WAIT   = 5'd15;
    localparam logic [4:0] S_RUN_INTERP = 5'd16;

    logic [4:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;
    logic       emit;

    always_comb
    begin
        out_free   = !out_valid_reg || !out_stall;
        state_next = state_reg;
        ctrl       = '{op: OP_NONE, status: ST_FINISHED};
        emit       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.op    = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.command)
                    CMD_MOVE:
                    begin
                        state_next = S_MOVE_CHK;
                    end
                    CMD_SPEED:
                    begin
                        if (stat.range_ok)
                        begin
                            state_next = S_SPD_MUL;
                        end
                        else if (out_free)
                        begin
                            ctrl       = '{op: OP_RESULT, status: ST_RANGE};
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    CMD_RUN:
                    begin
                        if (stat.run_ok)
                        begin
                            state_next = S_RUN_MUL;
                        end
                        else if (out_free)
                        begin
                            ctrl       = '{op: OP_RESULT, status: ST_FINISHED};
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            ctrl       = '{op: OP_RESULT, status: ST_FINISHED};
                            emit       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_MOVE_CHK:
            begin
                if (stat.range_ok && !stat.too_fast)
                begin
                    state_next = S_TRV_MUL;
                end
                else if (out_free)
                begin
                    ctrl.op     = OP_RESULT;
                    ctrl.status = stat.range_ok ? ST_FAST : ST_RANGE;
                    emit        = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_TRV_MUL:
            begin
                ctrl.op    = OP_MUL_TRAVEL;
                state_next = S_TRV_DIV;
            end
            S_TRV_DIV:
            begin
                ctrl.op    = OP_DIV_TRAVEL;
                state_next = S_TRV_WAIT;
            end
            S_TRV_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_DEG_MUL1;
                end
            end
            S_DEG_MUL1:
            begin
                ctrl.op    = OP_MUL_V;
                state_next = S_DEG_MUL2;
            end
            S_DEG_MUL2:
            begin
                ctrl.op    = OP_MUL_DEG;
                state_next = S_MV_COMMIT;
            end
            S_MV_COMMIT:
            begin
                if (out_free)
                begin
                    ctrl.op    = OP_COMMIT_MOVE;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SPD_MUL:
            begin
                ctrl.op    = OP_MUL_TRAVEL;
                state_next = S_SPD_DIV;
            end
            S_SPD_DIV:
            begin
                ctrl.op    = OP_DIV_TRAVEL;
                state_next = S_SPD_WAIT;
            end
            S_SPD_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_SPD_COMMIT;
                end
            end
            S_SPD_COMMIT:
            begin
                if (out_free)
                begin
                    ctrl.op    = OP_COMMIT_SPEED;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RUN_MUL:
            begin
                ctrl.op    = OP_MUL_SPAN;
                state_next = S_RUN_DIV;
            end
            S_RUN_DIV:
            begin
                ctrl.op    = OP_DIV_SPAN;
                state_next = S_RUN_WAIT;
            end
            S_RUN_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_RUN_INTERP;
                end
            end
            S_RUN_INTERP:
            begin
                ctrl.op    = OP_INTERP;
                state_next = S_MOVE_CHK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

endmodule

FILE: hdl/servo_axis_motion_controller_core.sv
// servo axis motion controller, top level
// one transaction in flight, next input taken back in idle; a move: decode, move check,
// travel multiply, divide, angle multiplies, commit; a speed move: decode, travel multiply,
// divide, commit; a run step adds span multiply, divide, interpolation before the move check;
// others end in decode or move check; divisions wait on the 48-step divider; stalls add delay
// rst_n clears control state, axis state and settings to their defaults at once
module servo_axis_motion_controller_core #(
    parameter int POS_FRAC_BITS = 12,
    parameter int TIME_WIDTH    = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  samc_pkg::in_item_t             in_item,
    output logic                           out_valid,
    input  logic                           out_stall,
    output samc_pkg::out_item_t            out_item,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [samc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data
);
    import samc_pkg::*;

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    samc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    samc_datapath #(
        .POS_FRAC_BITS (POS_FRAC_BITS),
        .TIME_WIDTH    (TIME_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .in_item   (in_item),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_item  (out_item)
    );

endmodule

FILE: tb/tb.sv
// testbench for the servo axis motion controller core
`timescale 1ns / 1ps

module tb;
    import samc_pkg::*;

    class servo_scoreboard;
        out_item_t          pending[$];
        int                 errors;
        logic signed [15:0] lo_lim, hi_lim, zoff, gain;
        logic [15:0]        vmax;
        int signed          cur_pos, from_pos, to_pos;
        logic [31:0]        lock_until, t0, dur;

        function new();
            errors = 0;
            lo_lim = -16'sd32768;
            hi_lim = 16'sd32767;
            vmax = 16'd256;
            zoff = 16'sd0;
            gain = 16'sd4096;
            cur_pos = 0;
            from_pos = 0;
            to_pos = 0;
            lock_until = 0;
            t0 = 0;
            dur = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                CFG_MIN_POS:   lo_lim = data;
                CFG_MAX_POS:   hi_lim = data;
                CFG_MAX_SPEED: vmax = data;
                CFG_ZERO_OFF:  zoff = data;
                CFG_MAP_GAIN:  gain = data;
                default: ;
            endcase
        endfunction

        function logic [31:0] travel(int signed a, int signed b, logic [31:0] spd);
            longint signed d, mag, q;
            d = longint'(a) - longint'(b);
            mag = d < 0 ? -d : d;
            if (spd == 0)
                spd = 1;
            q = (mag * 256000) / (longint'(spd) << 12);
            return q[31:0];
        endfunction

        function logic [7:0] degrees(int signed p);
            longint signed v, w, deg;
            v = (longint'(p) + longint'(zoff)) * longint'(gain);
            w = v * 3754936;
            if (w < 0)
                return 8'd0;
            deg = w >>> 40;
            return deg > 255 ? 8'd255 : deg[7:0];
        endfunction

        function out_item_t do_move(int signed p, logic [31:0] now);
            out_item_t r;
            r.status = ST_MOVED;
            r.servo_angle = 8'd0;
            if (p < int'(lo_lim) || p > int'(hi_lim))
            begin
                r.status = ST_RANGE;
                return r;
            end
            if (lock_until > now)
            begin
                r.status = ST_FAST;
                return r;
            end
            lock_until = now + travel(cur_pos, p, {16'd0, vmax});
            r.servo_angle = degrees(p);
            cur_pos = p;
            return r;
        endfunction

        function out_item_t predict(in_item_t it);
            out_item_t     r;
            logic [31:0]   lim, s, el;
            int signed     p;
            longint signed prod, q;
            r.status = ST_FINISHED;
            r.servo_angle = 8'd0;
            p = int'(it.target_position);
            case (it.command)
                CMD_MOVE: r = do_move(p, it.now_ms);
                CMD_SPEED:
                begin
                    lim = vmax == 0 ? 32'd1 : {16'd0, vmax};
                    s = it.speed_req == 0 ? 32'd1 : {16'd0, it.speed_req};
                    if (p < int'(lo_lim) || p > int'(hi_lim))
                        r.status = ST_RANGE;
                    else
                    begin
                        r.status = ST_ACCEPTED;
                        if (s > lim)
                        begin
                            s = lim;
                            r.status = ST_CLAMPED;
                        end
                        dur = travel(cur_pos, p, s);
                        from_pos = cur_pos;
                        to_pos = p;
                        t0 = it.now_ms;
                    end
                end
                CMD_RUN:
                begin
                    el = it.now_ms - t0;
                    if (dur != 0 && el <= dur)
                    begin
                        prod = (longint'(to_pos) - longint'(from_pos))
                               * longint'({32'd0, el});
                        q = prod / longint'({32'd0, dur});
                        r = do_move(from_pos + int'(q), it.now_ms);
                    end
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note(in_item_t it);
            pending.push_back(predict(it));
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check(out_item_t got);
            out_item_t want;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %0d/%0d",
                    got.status, got.servo_angle));
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                    got.status, want.status));
            if (got.servo_angle !== want.servo_angle)
                report_mismatch($sformatf("servo_angle %0d, expected %0d",
                    got.servo_angle, want.servo_angle));
        endtask
    endclass

    logic                 clk, rst_n;
    logic                 in_valid, in_stall, out_valid, out_stall;
    in_item_t             in_item;
    out_item_t            out_item;
    logic                 cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    servo_scoreboard sb;
    int          gap_pct, stall_pct, hold_cycles;
    longint      cycles;
    logic [31:0] clock_ms;

    servo_axis_motion_controller_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 3000000)
            begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // receiver side stalls
    initial
    begin
        out_stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall = 1;
                hold_cycles--;
            end
            else
                out_stall = ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check(out_item);

    task automatic send(in_item_t it);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid = 0;
            @(negedge clk);
        end
        in_valid = 1;
        in_item = it;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        sb.note(it);
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic send_cmd(logic [1:0] c, logic signed [15:0] p, logic [15:0] s,
                            logic [31:0] now);
        in_item_t it;
        it.command = c;
        it.target_position = p;
        it.speed_req = s;
        it.now_ms = now;
        send(it);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = data;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic set_regs(logic [15:0] lo, logic [15:0] hi, logic [15:0] spd,
                            logic [15:0] zo, logic [15:0] g);
        drain();
        write_reg(CFG_MIN_POS, lo);
        write_reg(CFG_MAX_POS, hi);
        write_reg(CFG_MAX_SPEED, spd);
        write_reg(CFG_ZERO_OFF, zo);
        write_reg(CFG_MAP_GAIN, g);
    endtask

    function automatic logic [15:0] rand_pos();
        logic signed [15:0] lo, hi;
        lo = sb.lo_lim;
        hi = sb.hi_lim;
        if ($urandom_range(9) == 0 || lo > hi)
            return 16'($urandom_range(16'hffff));
        return 16'(int'(lo) + int'($urandom_range(int'(hi) - int'(lo))));
    endfunction

    task automatic random_items(int n);
        int          k;
        logic [31:0] span;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 5)
            begin
                send_cmd(2'($urandom_range(3)), 16'($urandom_range(16'hffff)),
                         16'($urandom_range(16'hffff)), $urandom);
            end
            else if (k < 25)
            begin
                clock_ms += $urandom_range(20);
                send_cmd(CMD_SPEED, rand_pos(), 16'($urandom_range(16'hffff)), clock_ms);
            end
            else if (k < 75)
            begin
                span = sb.dur > 32'd4000000 ? 32'd4000000 : sb.dur;
                if ($urandom_range(7) == 0)
                    clock_ms = sb.t0 + span + $urandom_range(3);
                else
                    clock_ms = sb.t0 + $urandom_range(span) + 32'd0;
                if (sb.lock_until > clock_ms && $urandom_range(2) != 0)
                    clock_ms = sb.lock_until + $urandom_range(1);
                send_cmd(CMD_RUN, 16'($urandom_range(16'hffff)),
                         16'($urandom_range(16'hffff)), clock_ms);
            end
            else
            begin
                if ($urandom_range(3) != 0 && sb.lock_until > clock_ms)
                    clock_ms = sb.lock_until + $urandom_range(2);
                else
                    clock_ms += $urandom_range(50);
                send_cmd(CMD_MOVE, rand_pos(), 16'($urandom_range(16'hffff)), clock_ms);
            end
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 0;
        in_valid = 0;
        in_item = '0;
        cfg_valid = 0;
        cfg_index = CFG_MIN_POS;
        cfg_data = 16'd0;
        gap_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        clock_ms = 0;
        repeat (12) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: limits, rate lock, speed moves, run steps, unused command
        send_cmd(CMD_RUN, 16'sd0, 16'd1, 32'd0);
        send_cmd(CMD_MOVE, 16'sd32767, 16'hffff, 32'd0);
        send_cmd(CMD_MOVE, -16'sd32768, 16'd0, 32'd1);
        send_cmd(CMD_MOVE, -16'sd32768, 16'd0, 32'hffff_ffff);
        send_cmd(CMD_MOVE, 16'sd4096, 16'd0, 32'hffff_ffff);
        send_cmd(CMD_NOP, 16'sd100, 16'd100, 32'd5);
        send_cmd(CMD_SPEED, 16'sd0, 16'd0, 32'd1000);
        send_cmd(CMD_RUN, 16'sd0, 16'd0, 32'd1000);
        send_cmd(CMD_RUN, 16'sd0, 16'd0, 32'd1500);
        send_cmd(CMD_RUN, 16'sd0, 16'd0, 32'hffff_0000);
        send_cmd(CMD_SPEED, 16'sd8192, 16'hffff, 32'd2000);
        send_cmd(CMD_RUN, 16'sd0, 16'd0, 32'd2001);
        send_cmd(CMD_RUN, 16'sd0, 16'd0, 32'd1999);
        send_cmd(CMD_SPEED, 16'sd8192, 16'd0, 32'd3000);
        send_cmd(CMD_SPEED, -16'sd8192, 16'd128, 32'd3000);
        send_cmd(CMD_RUN, 16'sd0, 16'd0, 32'd4000);
        send_cmd(CMD_RUN, 16'sd0, 16'd0, 32'd9000);
        send_cmd(CMD_RUN, 16'sd0, 16'd0, 32'hffff_ffff);

        set_regs(16'hf000, 16'h1000, 16'd0, 16'h8000, 16'h8000);
        send_cmd(CMD_MOVE, 16'sh1001, 16'd5, 32'd0);
        send_cmd(CMD_SPEED, -16'sh1001, 16'd5, 32'd0);
        send_cmd(CMD_SPEED, 16'sh1000, 16'd5, 32'd100);
        send_cmd(CMD_MOVE, 16'shf000, 16'd5, 32'hffff_ffff);
        send_cmd(CMD_MOVE, 16'sh0000, 16'd5, 32'hffff_ffff);
        clock_ms = 32'hffff_ff00;

        // random items with several settings, extremes among them
        set_regs(16'h8000, 16'h7fff, 16'd256, 16'd0, 16'd4096);
        random_items(300);
        gap_pct = 50;
        set_regs(16'h8000, 16'h7fff, 16'hffff, 16'h7fff, 16'h7fff);
        random_items(300);
        gap_pct = 0;
        stall_pct = 50;
        set_regs(16'hc000, 16'h4000, 16'd1, 16'h0800, 16'hf000);
        random_items(300);
        gap_pct = 23;
        stall_pct = 23;
        set_regs(16'hf800, 16'h3000, 16'd1024, 16'h8000, 16'd2048);
        random_items(300);
        gap_pct = 0;
        stall_pct = 0;
        set_regs(16'h8000, 16'h7fff, 16'd300, 16'h1000, 16'h1000);
        hold_cycles = 400;
        random_items(320);

        drain();
        if (sb.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

FILE: files.f
hdl/samc_pkg.sv
hdl/samc_div.sv
hdl/samc_datapath.sv
hdl/samc_ctrl.sv
hdl/servo_axis_motion_controller_core.sv
tb/tb.sv
